// ===== rtl/core/multi_channel_hysteresis_thermostat_defines.svh =====
// Assertion macros for the hysteresis thermostat RTL.
// Included by the top module, which carries concurrent checks; no other dependencies.
`ifndef MULTI_CHANNEL_HYSTERESIS_THERMOSTAT_DEFINES_SVH
`define MULTI_CHANNEL_HYSTERESIS_THERMOSTAT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MCHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MCHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mcht_pkg.sv =====
// Shared types and constants for the hysteresis thermostat block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mcht_pkg;

    // Number of lights with a rule (1..8, one relay bit each)
    localparam int NUM_LIGHTS = 6;
    localparam int IDX_W      = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int TEMP_W  = 10;
    localparam int RELAY_W = 8;
    localparam int IN_W    = 104;
    localparam int OUT_W   = 32;
    localparam int ADDR_W  = 5;

    // Action codes (stream tuser)
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_SET_MODE = 2'd1;
    localparam logic [1:0] ACT_SET_SP   = 2'd2;
    localparam logic [1:0] ACT_SAVE     = 2'd3;

    // Rule mode codes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ABOVE = 2'd1;
    localparam logic [1:0] MODE_BELOW = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_HYST     = 3'd0;
    localparam logic [2:0] REG_SP_MIN   = 3'd1;
    localparam logic [2:0] REG_SP_MAX   = 3'd2;
    localparam logic [2:0] REG_INTERVAL = 3'd3;
    localparam logic [2:0] REG_SETTLE   = 3'd4;
    localparam logic [2:0] REG_MAX_AGE  = 3'd5;

    // Reset values
    localparam logic [4:0]         RST_HYST      = 5'd2;
    localparam logic signed [9:0]  RST_SP_MIN    = 10'sd40;
    localparam logic signed [9:0]  RST_SP_MAX    = 10'sd99;
    localparam logic [15:0]        RST_INTERVAL  = 16'd2000;
    localparam logic [15:0]        RST_SETTLE    = 16'd1500;
    localparam logic [31:0]        RST_MAX_AGE   = 32'd300000;
    localparam logic signed [9:0]  RST_SETPOINT  = 10'sd74;

    // Configuration as seen by the core
    typedef struct packed {
        logic [4:0]         hyst;
        logic signed [9:0]  sp_min;
        logic signed [9:0]  sp_max;
        logic [15:0]        interval;
        logic [15:0]        settle;
        logic [31:0]        max_age;
    } t_cfg;

    // Sign-extend a temperature to the shared unit width
    function automatic logic [TIME_W-1:0] sext_temp(input logic [TEMP_W-1:0] v);
        return {{(TIME_W-TEMP_W){v[TEMP_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mcht_alu.sv =====
// Shared subtract/compare unit of the thermostat sequencer.
// Depends on mcht_pkg for the operand width.
`default_nettype none

module mcht_alu
    import mcht_pkg::*;
(
    input  wire logic [TIME_W-1:0] i_a,
    input  wire logic [TIME_W-1:0] i_b,
    input  wire logic              i_signed,
    output logic      [TIME_W-1:0] o_diff,
    output logic                   o_lt
);

    logic [TIME_W:0] w_a;
    logic [TIME_W:0] w_b;
    logic [TIME_W:0] w_sub;

    // One extra bit: its value after the subtract is the a < b flag
    always_comb begin
        w_a   = {i_signed & i_a[TIME_W-1], i_a};
        w_b   = {i_signed & i_b[TIME_W-1], i_b};
        w_sub = w_a - w_b;
    end

    assign o_diff = w_sub[TIME_W-1:0];
    assign o_lt   = w_sub[TIME_W];

endmodule

`default_nettype wire

// ===== rtl/core/mcht_cfg.sv =====
// APB register file for the thermostat configuration.
// Depends on mcht_pkg for register indexes, reset values and t_cfg.
`default_nettype none

module mcht_cfg
    import mcht_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;

    // Register writes on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hyst     <= RST_HYST;
            r_cfg.sp_min   <= RST_SP_MIN;
            r_cfg.sp_max   <= RST_SP_MAX;
            r_cfg.interval <= RST_INTERVAL;
            r_cfg.settle   <= RST_SETTLE;
            r_cfg.max_age  <= RST_MAX_AGE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_HYST:     r_cfg.hyst     <= pwdata[4:0];
                REG_SP_MIN:   r_cfg.sp_min   <= pwdata[9:0];
                REG_SP_MAX:   r_cfg.sp_max   <= pwdata[9:0];
                REG_INTERVAL: r_cfg.interval <= pwdata[15:0];
                REG_SETTLE:   r_cfg.settle   <= pwdata[15:0];
                REG_MAX_AGE:  r_cfg.max_age  <= pwdata;
                default: ;
            endcase
        end
    end

    // Readback
    always_comb begin
        unique case (w_idx)
            REG_HYST:     prdata = {27'd0, r_cfg.hyst};
            REG_SP_MIN:   prdata = {22'd0, r_cfg.sp_min};
            REG_SP_MAX:   prdata = {22'd0, r_cfg.sp_max};
            REG_INTERVAL: prdata = {16'd0, r_cfg.interval};
            REG_SETTLE:   prdata = {16'd0, r_cfg.settle};
            REG_MAX_AGE:  prdata = r_cfg.max_age;
            default:      prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/multi_channel_hysteresis_thermostat.sv =====
// Multi-channel hysteresis thermostat: sequencer, rule store and output stage.
// Depends on mcht_pkg, mcht_alu, mcht_cfg and the assertion macro header.
//
//  Port group   Dir  Beat holds
//  s_*          in   tuser: action; tdata: now, light, mode, setpoint, reading, relays
//  m_*          out  tdata: drive mask/level, rule readback, dirty flag
//  APB          in   six configuration registers at 4*index
//
// A tick checks the evaluation interval, then a pending edit against the settle time,
// then the age of the reading, then evaluates every light in turn; a setpoint edit is
// clamped before it is written. All work goes through one shared subtract/compare
// unit. s_tready is high only while the sequencer is idle. A finished result sits in
// the output register; the next beat is taken while it waits. Synchronous active-low
// reset clears rules, timers and flags.
`default_nettype none
`include "multi_channel_hysteresis_thermostat_defines.svh"

module multi_channel_hysteresis_thermostat
    import mcht_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // tdata: now_ms[31:0], light[35:32], new_mode[37:36], new_setpoint[47:38],
    //        room_valid[48], room_stamp_ms[80:49], room_temp[90:81],
    //        relay_now[98:91], zero pad[103:99]
    input  wire logic [IN_W-1:0]   s_tdata,
    // tuser: action[1:0]
    input  wire logic [1:0]        s_tuser,
    // Output stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // tdata: drive_mask[7:0], drive_level[15:8], read_mode[17:16],
    //        read_setpoint[27:18], rules_dirty[28], zero pad[31:29]
    output logic      [OUT_W-1:0]  m_tdata,
    // Configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_EV_SUB  = 14'b00000000000010,
        S_EV_CMP  = 14'b00000000000100,
        S_ED_SUB  = 14'b00000000001000,
        S_ED_CMP  = 14'b00000000010000,
        S_AGE_SUB = 14'b00000000100000,
        S_AGE_CMP = 14'b00000001000000,
        S_L_SUB   = 14'b00000010000000,
        S_L_CMP   = 14'b00000100000000,
        S_CLMP_LO = 14'b00001000000000,
        S_CLMP_HI = 14'b00010000000000,
        S_EDIT    = 14'b00100000000000,
        S_READ    = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cfg   w_cfg;

    // Captured input beat
    logic [1:0]          r_action;
    logic [TIME_W-1:0]   r_now;
    logic [1:0]          r_new_mode;
    logic [TEMP_W-1:0]   r_sp;
    logic                r_room_valid;
    logic [TIME_W-1:0]   r_stamp;
    logic [TEMP_W-1:0]   r_temp;
    logic [RELAY_W-1:0]  r_relay;
    logic                r_ok;
    logic [IDX_W-1:0]    r_lsel;

    // Rule store and timers
    logic [1:0]            r_mode [NUM_LIGHTS];
    logic [TEMP_W-1:0]     r_spt  [NUM_LIGHTS];
    logic [NUM_LIGHTS-1:0] r_out;
    logic [NUM_LIGHTS-1:0] r_has;
    logic                  r_dirty;
    logic [TIME_W-1:0]     r_last_eval;
    logic                  r_pending;
    logic [TIME_W-1:0]     r_last_edit;

    // Working registers
    logic [IDX_W-1:0]   r_idx;
    logic [TIME_W-1:0]  r_d;
    logic [RELAY_W-1:0] r_mask;
    logic [RELAY_W-1:0] r_level;
    logic               r_ovalid;
    logic [OUT_W-1:0]   r_odata;

    // Shared unit
    logic [TIME_W-1:0] w_a;
    logic [TIME_W-1:0] w_b;
    logic              w_sgn;
    logic [TIME_W-1:0] w_diff;
    logic              w_lt;

    logic              w_in_acc;
    logic              w_out_free;
    logic [3:0]        w_light;
    logic              w_light_ok;
    logic [1:0]        w_cur_mode;
    logic [TEMP_W-1:0] w_cur_sp;
    logic              w_cur_on;
    logic              w_le0;
    logic              w_want;
    logic              w_last_idx;
    logic              w_mode_chg;
    logic              w_sp_chg;

    mcht_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mcht_alu u_alu (
        .i_a      (w_a),
        .i_b      (w_b),
        .i_signed (w_sgn),
        .o_diff   (w_diff),
        .o_lt     (w_lt)
    );

    assign s_tready   = (r_state == S_IDLE);
    assign w_in_acc   = s_tvalid & s_tready;
    assign w_out_free = ~r_ovalid | m_tready;
    assign m_tvalid   = r_ovalid;
    assign m_tdata    = r_odata;

    assign w_light    = s_tdata[35:32];
    assign w_light_ok = (w_light < 4'(NUM_LIGHTS));

    // Rule at the working index
    assign w_cur_mode = r_mode[r_idx];
    assign w_cur_sp   = r_spt[r_idx];
    assign w_cur_on   = r_out[r_idx];
    assign w_last_idx = (r_idx == IDX_W'(NUM_LIGHTS - 1));
    assign w_mode_chg = r_ok && (r_new_mode <= MODE_BELOW) && (w_cur_mode != r_new_mode);
    assign w_sp_chg   = r_ok && (w_cur_sp != r_sp);

    // Hysteresis decision; r_d is the signed distance from the "on" side, zero or less inside it
    assign w_le0 = r_d[TIME_W-1] | (r_d == '0);
    always_comb begin
        if (w_cur_mode == MODE_ABOVE || w_cur_mode == MODE_BELOW) begin
            w_want = w_cur_on ? w_lt : w_le0;
        end else begin
            w_want = w_cur_on;
        end
    end

    // Operand selection for the shared unit
    always_comb begin
        w_a   = r_d;
        w_b   = '0;
        w_sgn = 1'b0;
        unique case (r_state)
            S_EV_SUB: begin
                w_a = r_now;
                w_b = r_last_eval;
            end
            S_EV_CMP: begin
                w_a = r_d;
                w_b = {16'd0, w_cfg.interval};
            end
            S_ED_SUB: begin
                w_a = r_now;
                w_b = r_last_edit;
            end
            S_ED_CMP: begin
                w_a = r_d;
                w_b = {16'd0, w_cfg.settle};
            end
            S_AGE_SUB: begin
                w_a = r_now;
                w_b = r_stamp;
            end
            S_AGE_CMP: begin
                w_a = w_cfg.max_age;
                w_b = r_d;
            end
            S_L_SUB: begin
                w_sgn = 1'b1;
                if (w_cur_mode == MODE_ABOVE) begin
                    w_a = sext_temp(w_cur_sp);
                    w_b = sext_temp(r_temp);
                end else begin
                    w_a = sext_temp(r_temp);
                    w_b = sext_temp(w_cur_sp);
                end
            end
            S_L_CMP: begin
                w_sgn = 1'b1;
                w_a   = r_d;
                w_b   = {27'd0, w_cfg.hyst};
            end
            S_CLMP_LO: begin
                w_sgn = 1'b1;
                w_a   = sext_temp(r_sp);
                w_b   = sext_temp(w_cfg.sp_min);
            end
            S_CLMP_HI: begin
                w_sgn = 1'b1;
                w_a   = sext_temp(w_cfg.sp_max);
                w_b   = sext_temp(r_sp);
            end
            default: ;
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (s_tuser)
                        ACT_TICK:     n_state = S_EV_SUB;
                        ACT_SET_MODE: n_state = S_EDIT;
                        ACT_SET_SP:   n_state = S_CLMP_LO;
                        default:      n_state = S_READ;
                    endcase
                end
            end
            S_EV_SUB: n_state = S_EV_CMP;
            S_EV_CMP: begin
                if (w_lt) begin
                    n_state = S_READ;
                end else if (r_pending) begin
                    n_state = S_ED_SUB;
                end else begin
                    n_state = r_room_valid ? S_AGE_SUB : S_READ;
                end
            end
            S_ED_SUB: n_state = S_ED_CMP;
            S_ED_CMP: begin
                if (w_lt || !r_room_valid) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_AGE_SUB;
                end
            end
            S_AGE_SUB: n_state = S_AGE_CMP;
            S_AGE_CMP: n_state = w_lt ? S_READ : S_L_SUB;
            S_L_SUB:   n_state = S_L_CMP;
            S_L_CMP:   n_state = w_last_idx ? S_READ : S_L_SUB;
            S_CLMP_LO: n_state = S_CLMP_HI;
            S_CLMP_HI: n_state = S_EDIT;
            S_EDIT:    n_state = S_READ;
            S_READ:    n_state = S_OUT;
            S_OUT:     n_state = w_out_free ? S_IDLE : S_OUT;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control state, rule store and timers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dirty     <= 1'b0;
            r_pending   <= 1'b0;
            r_last_eval <= '0;
            r_last_edit <= '0;
            r_out       <= '0;
            r_has       <= '0;
            r_idx       <= '0;
            r_ovalid    <= 1'b0;
            for (int i = 0; i < NUM_LIGHTS; i++) begin
                r_mode[i] <= MODE_OFF;
                r_spt[i]  <= RST_SETPOINT;
            end
        end else begin
            r_state <= n_state;
            // S_OUT reloads the output register itself
            if (r_ovalid && m_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_idx <= w_light_ok ? w_light[IDX_W-1:0] : '0;
                        if (s_tuser == ACT_SAVE) begin
                            r_dirty <= 1'b0;
                        end
                    end
                end
                S_EV_CMP: begin
                    if (!w_lt) begin
                        r_last_eval <= r_now;
                    end
                end
                S_ED_CMP: begin
                    if (!w_lt) begin
                        r_pending <= 1'b0;
                    end
                end
                S_AGE_CMP: r_idx <= '0;
                S_L_CMP: begin
                    if (w_cur_mode == MODE_OFF) begin
                        r_out[r_idx] <= 1'b0;
                        r_has[r_idx] <= 1'b0;
                    end else if (!r_has[r_idx] || (w_want != w_cur_on)) begin
                        r_out[r_idx] <= w_want;
                        r_has[r_idx] <= 1'b1;
                    end
                    if (!w_last_idx) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EDIT: begin
                    if ((r_action == ACT_SET_MODE && w_mode_chg) ||
                        (r_action == ACT_SET_SP && w_sp_chg)) begin
                        if (r_action == ACT_SET_MODE) begin
                            r_mode[r_idx] <= r_new_mode;
                        end else begin
                            r_spt[r_idx] <= r_sp;
                        end
                        r_out[r_idx] <= 1'b0;
                        r_has[r_idx] <= 1'b0;
                        r_pending    <= 1'b1;
                        r_last_edit  <= r_now;
                        r_dirty      <= 1'b1;
                    end
                end
                S_READ: r_idx <= r_lsel;
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload: captured beat, working values, output register
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_action     <= s_tuser;
            r_now        <= s_tdata[31:0];
            r_new_mode   <= s_tdata[37:36];
            r_sp         <= s_tdata[47:38];
            r_room_valid <= s_tdata[48];
            r_stamp      <= s_tdata[80:49];
            r_temp       <= s_tdata[90:81];
            r_relay      <= s_tdata[98:91];
            r_ok         <= w_light_ok;
            r_lsel       <= w_light_ok ? w_light[IDX_W-1:0] : '0;
            r_mask       <= '0;
            r_level      <= '0;
        end
        // Differences from the shared unit
        if (r_state == S_EV_SUB || r_state == S_ED_SUB || r_state == S_AGE_SUB ||
            r_state == S_L_SUB) begin
            r_d <= w_diff;
        end
        // Setpoint clamp: up to the minimum, then down to the maximum
        if (r_state == S_CLMP_LO && w_lt) begin
            r_sp <= w_cfg.sp_min;
        end
        if (r_state == S_CLMP_HI && w_lt) begin
            r_sp <= w_cfg.sp_max;
        end
        // Relay drive where the decision is new or changed and the relay disagrees
        if (r_state == S_L_CMP && w_cur_mode != MODE_OFF &&
            (!r_has[r_idx] || (w_want != w_cur_on)) && (r_relay[r_idx] != w_want)) begin
            r_mask[r_idx]  <= 1'b1;
            r_level[r_idx] <= w_want;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_odata <= {3'd0, r_dirty,
                        r_ok ? w_cur_sp : {TEMP_W{1'b0}},
                        r_ok ? w_cur_mode : MODE_OFF,
                        r_level, r_mask};
        end
    end

    // Checks
    `MCHT_ASSERT_NOW(a_level_in_mask, i_clk, i_rst_n, r_ovalid,
        (r_odata[15:8] & ~r_odata[7:0]) == 8'd0, "drive level outside drive mask")
    `MCHT_ASSERT_NOW(a_mask_in_range, i_clk, i_rst_n, r_ovalid,
        (r_odata[7:0] >> NUM_LIGHTS) == 8'd0, "drive mask names a missing light")
    `MCHT_ASSERT_NOW(a_off_no_output, i_clk, i_rst_n, w_cur_mode == MODE_OFF,
        !r_has[r_idx], "light in off mode holds an output")
    `MCHT_ASSERT_NOW(a_output_needs_valid, i_clk, i_rst_n, !r_has[r_idx],
        !r_out[r_idx], "held output set without its valid bit")
    `MCHT_ASSERT_NEXT(a_result_posted, i_clk, i_rst_n, r_state == S_OUT && !r_ovalid,
        r_ovalid && r_state == S_IDLE, "finished item did not post its result")

endmodule

`default_nettype wire
